### src/wds_pkg.sv
// ----------------------------------------------------------------------------
// wds_pkg: shared types and constants of the walk direction segmenter
// Window length, command and status codes, and the classified entry that
// travels from the front end to the segment tracker.
// ----------------------------------------------------------------------------
package wds_pkg;

   // frames in the depth ring (2 to 15)
   localparam int unsigned WINDOW = 10;
   localparam int unsigned FILL_W = $clog2(WINDOW + 1);
   localparam int unsigned TAPS = WINDOW - 1;

   localparam int unsigned DEPTH_W = 16;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned DEB_W = 4;
   localparam int unsigned STATUS_W = 2;

   localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 4'd5;

   // input command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_END = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_TURN = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_END = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ABORT = 2'd2;

   // classified operations handed to the tracker
   typedef enum logic [1:0] {
      OP_INIT,
      OP_SAMPLE,
      OP_END,
      OP_ABORT
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               forward;
      logic [TIME_W-1:0]  frame_time;
   } entry_type;

   typedef struct packed {
      logic [TIME_W-1:0]   segment_start;
      logic [TIME_W-1:0]   segment_end;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

### src/walk_direction_segmenter_top.sv
// ----------------------------------------------------------------------------
// walk_direction_segmenter_top: forward walking segment detector
// Splits a stream of depth frames into forward segments with debounced
// direction changes.
// ----------------------------------------------------------------------------
// Usage
//   req_* takes one frame per transfer: tuser is the command (sample or end
//   of stream), tdata carries depth and timestamp. rsp_* gives one closed
//   segment per transfer: start time, end time and status.
//   csr_* is an APB port with one register, debounce_count at address 0
//   (reset value 5); write it only while the block is idle.
// Pipeline and throughput
//   One frame per cycle sustained while the queue has room. A frame is
//   classified in the cycle it is taken and waits in a two-entry queue;
//   the tracker puts its result, if any, in the result register, which
//   offers it on rsp_*. The direction compare is one 17-bit subtract
//   against the history line.
// Reset
//   Clears fill count, direction state, queue pointers and result valid;
//   the depth history is not cleared, a stream refills it before use.
// Stalls
//   When rsp_tready is low the result register holds; the queue absorbs
//   two more operations, then req_tready drops.
// ----------------------------------------------------------------------------
module walk_direction_segmenter_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // depth_mm[15:0], frame_time[47:16]
   input  logic        req_tuser,   // command
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // segment_start[31:0], segment_end[63:32],
                                    // status[65:64], zero[71:66]
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [wds_pkg::DEB_W-1:0] debounce_ff, debounce_in;
   logic                      req_accept;
   logic                      push, space, pop, pending;
   wds_pkg::entry_type        push_entry, head;
   wds_pkg::result_type       result;

   // register file: one register, decoded on the word address
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {28'd0, debounce_ff} : 32'd0;

   always_comb begin
      debounce_in = debounce_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == 1'b0) begin
         debounce_in = csr_pwdata[wds_pkg::DEB_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= wds_pkg::DEBOUNCE_RESET;
      end else begin
         debounce_ff <= debounce_in;
      end
   end

   // take a frame whenever the queue has room
   assign req_tready = space;
   assign req_accept = req_tvalid && space;

   wds_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .command    (req_tuser),
      .depth_mm   (req_tdata[15:0]),
      .frame_time (req_tdata[47:16]),
      .push       (push),
      .push_entry (push_entry)
   );

   wds_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .space      (space),
      .pop        (pop),
      .pending    (pending),
      .head       (head)
   );

   wds_back u_back (
      .clock      (clock),
      .reset      (reset),
      .debounce   (debounce_ff),
      .pending    (pending),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_taken  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {6'd0, result.status, result.segment_end, result.segment_start};

endmodule

### src/wds_front.sv
// ----------------------------------------------------------------------------
// wds_front: frame intake and classification
// Keeps the depth history line and fill count, works out the direction of
// each frame and turns it into a tracker operation.
// ----------------------------------------------------------------------------
module wds_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          command,
   input  logic signed [wds_pkg::DEPTH_W-1:0] depth_mm,
   input  logic [wds_pkg::TIME_W-1:0]    frame_time,
   output logic                          push,
   output wds_pkg::entry_type            push_entry
);

   logic signed [wds_pkg::DEPTH_W-1:0] taps_ff [wds_pkg::TAPS];
   logic [wds_pkg::FILL_W-1:0]         fill_ff;
   logic [wds_pkg::FILL_W-1:0]         fill_in;
   logic signed [wds_pkg::DEPTH_W:0]   delta;
   logic                               filled;

   // newest minus the frame WINDOW-1 frames back
   assign delta = {depth_mm[wds_pkg::DEPTH_W-1], depth_mm}
                - {taps_ff[wds_pkg::TAPS-1][wds_pkg::DEPTH_W-1], taps_ff[wds_pkg::TAPS-1]};
   assign filled = (fill_ff == wds_pkg::FILL_W'(wds_pkg::WINDOW));

   always_comb begin
      fill_in = fill_ff;
      push = 1'b0;
      push_entry.op = wds_pkg::OP_SAMPLE;
      push_entry.forward = ~delta[wds_pkg::DEPTH_W];
      push_entry.frame_time = frame_time;
      if (accept) begin
         priority if (command == wds_pkg::CMD_END) begin
            push = 1'b1;
            push_entry.op = filled ? wds_pkg::OP_END : wds_pkg::OP_ABORT;
            fill_in = '0;
         end else if (!filled) begin
            fill_in = fill_ff + 1'b1;
            if (fill_in == wds_pkg::FILL_W'(wds_pkg::WINDOW)) begin
               push = 1'b1;
               push_entry.op = wds_pkg::OP_INIT;
            end
         end else begin
            push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // history line: no reset, every tap is written before it is read
   always_ff @(posedge clock) begin
      if (accept && command == wds_pkg::CMD_SAMPLE) begin
         taps_ff[0] <= depth_mm;
         for (int i = 1; i < wds_pkg::TAPS; i++) begin
            taps_ff[i] <= taps_ff[i-1];
         end
      end
   end

endmodule

### src/wds_queue.sv
// ----------------------------------------------------------------------------
// wds_queue: two-entry queue between front end and tracker
// Lets the intake and the tracker stall independently.
// ----------------------------------------------------------------------------
module wds_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wds_pkg::entry_type push_entry,
   output logic               space,
   input  logic               pop,
   output logic               pending,
   output wds_pkg::entry_type head
);

   wds_pkg::entry_type slots_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   assign space = (count_ff != 2'd2);
   assign pending = (count_ff != 2'd0);
   assign head = slots_ff[rd_ff];

   always_comb begin
      wr_in = push ? ~wr_ff : wr_ff;
      rd_in = pop ? ~rd_ff : rd_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_entry;
      end
   end

endmodule

### src/wds_back.sv
// ----------------------------------------------------------------------------
// wds_back: direction debounce and segment tracker
// Applies one op a cycle unless rsp_* stalls, and holds the result register.
// ----------------------------------------------------------------------------
module wds_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [wds_pkg::DEB_W-1:0]  debounce,
   input  logic                       pending,
   input  wds_pkg::entry_type         head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_taken,
   output wds_pkg::result_type        rsp_result
);

   logic                        cur_ff, cur_in;
   logic                        prev_ff, prev_in;
   logic [wds_pkg::DEB_W-1:0]   change_ff, change_in;
   logic [wds_pkg::TIME_W-1:0]  start_ff, start_in;
   logic [wds_pkg::TIME_W-1:0]  latest_ff, latest_in;
   logic                        valid_ff, valid_in;
   wds_pkg::result_type         result_ff, result_in;
   logic [wds_pkg::DEB_W:0]     next_count;
   logic                        emit;

   assign pop = pending && (!valid_ff || rsp_taken);
   assign rsp_valid = valid_ff;
   assign rsp_result = result_ff;

   always_comb begin
      cur_in = cur_ff;
      prev_in = prev_ff;
      change_in = change_ff;
      start_in = start_ff;
      latest_in = latest_ff;
      emit = 1'b0;
      result_in = result_ff;
      next_count = (head.forward == prev_ff) ? {1'b0, change_ff} + 1'b1 : '0;
      if (pop) begin
         unique case (head.op)
            wds_pkg::OP_INIT: begin
               cur_in = head.forward;
               prev_in = head.forward;
               change_in = '0;
               start_in = '0;
               latest_in = head.frame_time;
            end
            wds_pkg::OP_SAMPLE: begin
               latest_in = head.frame_time;
               prev_in = head.forward;
               if (head.forward != cur_ff) begin
                  if (next_count >= {1'b0, debounce}) begin
                     // adopt the new direction
                     cur_in = head.forward;
                     change_in = '0;
                     if (head.forward) begin
                        start_in = head.frame_time;
                     end else begin
                        emit = 1'b1;
                        result_in.segment_start = start_ff;
                        result_in.segment_end = head.frame_time;
                        result_in.status = wds_pkg::STATUS_TURN;
                        start_in = '0;
                     end
                  end else begin
                     change_in = next_count[wds_pkg::DEB_W-1:0];
                  end
               end
            end
            wds_pkg::OP_END: begin
               emit = cur_ff;
               result_in.segment_start = start_ff;
               result_in.segment_end = latest_ff;
               result_in.status = wds_pkg::STATUS_END;
            end
            wds_pkg::OP_ABORT: begin
               emit = 1'b1;
               result_in.segment_start = '0;
               result_in.segment_end = '0;
               result_in.status = wds_pkg::STATUS_ABORT;
            end
            default: begin
            end
         endcase
         if (head.op == wds_pkg::OP_END || head.op == wds_pkg::OP_ABORT) begin
            cur_in = 1'b0;
            prev_in = 1'b0;
            change_in = '0;
            start_in = '0;
            latest_in = '0;
         end
      end
      if (pop) begin
         valid_in = emit;
      end else if (rsp_taken) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= 1'b0;
         prev_ff <= 1'b0;
         change_ff <= '0;
         start_ff <= '0;
         latest_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         cur_ff <= cur_in;
         prev_ff <= prev_in;
         change_ff <= change_in;
         start_ff <= start_in;
         latest_ff <= latest_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         result_ff <= result_in;
      end
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for walk_direction_segmenter_top
// Drives depth frames and end markers into the request stream, predicts the
// closed walking segments with a cycle-free model of the debounced direction
// tracker, and checks every result transfer field by field. A short table of
// directed frames comes first, then randomised walks under several debounce
// settings with bursty input and a stalling result receiver.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [2:0] REG_DEBOUNCE = 3'd0;
   localparam int PHASES = 8;
   localparam int PHASE_FRAMES = 168;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int IDLE_LIMIT = 3000;

   // short names for the command and status codes, used by the script
   localparam logic       SAMPLE = wds_pkg::CMD_SAMPLE;
   localparam logic       MARKER = wds_pkg::CMD_END;
   localparam logic [1:0] TURN = wds_pkg::STATUS_TURN;
   localparam logic [1:0] CLOSED = wds_pkg::STATUS_END;
   localparam logic [1:0] ABORTED = wds_pkg::STATUS_ABORT;

   typedef struct packed {
      logic               command;
      logic signed [15:0] depth;
      logic [31:0]        stamp;
   } frame_type;

   typedef enum logic {ROW_FRAME, ROW_CSR} row_kind_type;

   // one line of the directed script; typed rows carry their own result
   typedef struct {
      row_kind_type kind;
      logic         command;
      logic [15:0]  depth;
      logic [31:0]  stamp;
      bit           typed;
      logic [31:0]  want_start;
      logic [31:0]  want_end;
      logic [1:0]   want_status;
      logic [3:0]   setting;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   walk_direction_segmenter_top dut (.*);

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: depth ring, debounced direction and open segment
   // ---------------------------------------------------------------------
   logic signed [15:0] depth_ring [wds_pkg::WINDOW];
   int unsigned        ring_wr = 0;
   int unsigned        ring_fill = 0;
   bit                 dir_now = 1'b0;
   bit                 dir_last = 1'b0;
   int unsigned        turn_votes = 0;
   logic [31:0]        seg_open = '0;
   logic [31:0]        last_time = '0;
   logic [3:0]         debounce_reg = wds_pkg::DEBOUNCE_RESET;

   wds_pkg::result_type segment_due [$];

   int errors = 0;
   int frames_sent = 0;
   int markers_sent = 0;
   int settings_used = 0;
   int turns_seen = 0;
   int ends_seen = 0;
   int aborts_seen = 0;
   int idle_cycles = 0;
   bit long_hold_due = 1'b0;

   // random walk generator state
   int          walk_left = 150;
   int          walk_depth = 0;
   int          trend_step = 0;
   int          trend_left = 0;
   logic [31:0] walk_stamp = 32'd1000;

   // forward when newest minus oldest depth is not negative
   function automatic bit heading(input int unsigned newest);
      return (int'(depth_ring[newest]) - int'(depth_ring[ring_wr])) >= 0;
   endfunction

   // advance the tracker by one frame; returns 1 when a segment closes
   function automatic bit track_frame(input frame_type f, output wds_pkg::result_type seg);
      int unsigned newest;
      int unsigned next_votes;
      bit          dir;
      bit          produced;
      seg = '0;
      produced = 1'b0;
      if (f.command == MARKER) begin
         if (ring_fill < wds_pkg::WINDOW) begin
            seg.status = ABORTED;
            produced = 1'b1;
         end else if (dir_now) begin
            seg.segment_start = seg_open;
            seg.segment_end = last_time;
            seg.status = CLOSED;
            produced = 1'b1;
         end
         // start a fresh stream; the debounce setting survives
         ring_wr = 0;
         ring_fill = 0;
         dir_now = 1'b0;
         dir_last = 1'b0;
         turn_votes = 0;
         seg_open = '0;
         last_time = '0;
         return produced;
      end
      newest = ring_wr;
      depth_ring[newest] = f.depth;
      ring_wr = (newest + 1 >= wds_pkg::WINDOW) ? 0 : newest + 1;
      last_time = f.stamp;
      if (ring_fill < wds_pkg::WINDOW) begin
         ring_fill++;
         if (ring_fill == wds_pkg::WINDOW) begin
            dir_now = heading(newest);
            dir_last = dir_now;
            turn_votes = 0;
            seg_open = '0;
         end
         return 1'b0;
      end
      dir = heading(newest);
      if (dir != dir_now) begin
         next_votes = (dir == dir_last) ? turn_votes + 1 : 0;
         if (next_votes >= debounce_reg) begin
            dir_now = dir;
            dir_last = dir;
            turn_votes = 0;
            if (dir) begin
               seg_open = f.stamp;
               return 1'b0;
            end
            seg.segment_start = seg_open;
            seg.segment_end = f.stamp;
            seg.status = TURN;
            seg_open = '0;
            return 1'b1;
         end
         turn_votes = next_votes;
      end
      dir_last = dir;
      return 1'b0;
   endfunction

   // next frame of a random walk: mostly whole streams with trends and
   // jitter, some full-range noise, some streams cut short before the fill
   function automatic frame_type next_walk_frame();
      frame_type f;
      f.command = SAMPLE;
      if (walk_left == 0) begin
         f.command = MARKER;
         f.depth = 16'($urandom);
         f.stamp = $urandom;
         walk_left = ($urandom_range(0, 6) == 0)
                   ? int'($urandom_range(0, wds_pkg::WINDOW - 1))
                   : int'($urandom_range(20, 200));
         walk_depth = int'($urandom_range(0, 50000)) - 25000;
         if ($urandom_range(0, 3) == 0) walk_stamp = $urandom;
         return f;
      end
      walk_left--;
      if (trend_left == 0) begin
         trend_step = int'($urandom_range(0, 60)) - 30;
         trend_left = $urandom_range(3, 40);
      end
      trend_left--;
      walk_depth += trend_step + int'($urandom_range(0, 6)) - 3;
      if (walk_depth > 32767) walk_depth = 32767;
      if (walk_depth < -32768) walk_depth = -32768;
      f.depth = 16'(walk_depth);
      if ($urandom_range(0, 19) == 0) f.depth = 16'($urandom);
      walk_stamp += $urandom_range(1, 40);
      if ($urandom_range(0, 49) == 0) walk_stamp = $urandom;
      f.stamp = walk_stamp;
      return f;
   endfunction

   // ---------------------------------------------------------------------
   // Directed script: extremes of depth and time, end marker on an empty
   // stream and mid-fill, initial forward segment closed at end of stream,
   // zero debounce turning both ways, end marker while walking backward
   // ---------------------------------------------------------------------
   script_row_type script [28] = '{
      '{ROW_FRAME, MARKER, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'd0, 32'd0, ABORTED, 4'd0},
      '{ROW_FRAME, SAMPLE, 16'h8000, 32'd0,         1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'hB1E0, 32'd1,         1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'hFFFF, 32'd2,         1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'h0000, 32'd3,         1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'h0001, 32'd4,         1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'h0007, 32'd5,         1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'h00FF, 32'd6,         1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'h1000, 32'd7,         1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'h7530, 32'd8,         1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'h7FFF, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, MARKER, 16'h0000, 32'd0,         1'b1, 32'd0, 32'hFFFF_FFFF, CLOSED, 4'd0},
      '{ROW_FRAME, SAMPLE, 16'h1234, 32'h5555_5555, 1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, MARKER, 16'h8000, 32'hAAAA_AAAA, 1'b1, 32'd0, 32'd0, ABORTED, 4'd0},
      '{ROW_CSR,   SAMPLE, 16'h0000, 32'd0,         1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'h7FFF, 32'd100,       1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'h7530, 32'd101,       1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'h4E20, 32'd102,       1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'h1000, 32'd103,       1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'h00FF, 32'd104,       1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'h0001, 32'd105,       1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'h0000, 32'd106,       1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'hFFFF, 32'd107,       1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'hB1E0, 32'd108,       1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'h8000, 32'd109,       1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'h7FFF, 32'd200,       1'b0, 32'd0, 32'd0, TURN,    4'd0},
      '{ROW_FRAME, SAMPLE, 16'h8000, 32'd201,       1'b1, 32'd200, 32'd201, TURN, 4'd0},
      '{ROW_FRAME, MARKER, 16'h0000, 32'd0,         1'b0, 32'd0, 32'd0, TURN,    4'd15}
   };

   // ---------------------------------------------------------------------
   // Configuration port: setup cycle, access cycle, then psel is released
   // before the task returns, so back-to-back accesses never collide in
   // one time step. A read is checked against the predictor's register copy.
   // ---------------------------------------------------------------------
   task automatic csr_access(input logic write, input logic [3:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= REG_DEBOUNCE;
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (write) begin
         debounce_reg = value;
      end else if (csr_prdata !== 32'(debounce_reg)) begin
         $display("%0t: debounce_count read expected %h actual %h",
                  $time, 32'(debounce_reg), csr_prdata);
         errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // drain every pending segment, let the pipeline settle, then reprogram
   task automatic apply_debounce(input logic [3:0] value);
      req_tvalid <= 1'b0;
      while (segment_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_access(1'b1, value);
      csr_access(1'b0, 4'd0);
      settings_used++;
   endtask

   // offer one frame after an optional gap; on the transfer, predict and
   // queue the segment it closes (or the typed one, where the row has it)
   task automatic offer_frame(input frame_type f, input int gap,
                              input bit typed, input wds_pkg::result_type given);
      wds_pkg::result_type seg;
      bit                  produced;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= f.command;
      req_tdata <= {f.stamp, f.depth};
      do @(posedge clock); while (!req_tready);
      frames_sent++;
      if (f.command == MARKER) markers_sent++;
      produced = track_frame(f, seg);
      if (typed) begin
         seg = given;
         produced = 1'b1;
      end
      if (produced) segment_due.insert(segment_due.size(), seg);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      frame_type           f;
      wds_pkg::result_type given;
      int                  burst_left;
      int                  gap;
      bit                  gappy;
      logic [3:0]          plan [5];
      logic [3:0]          setting;

      plan = '{4'd1, 4'd4, 4'd15, 4'd0, 4'd2};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of the register must read back before anything else
      csr_access(1'b0, 4'd0);

      // walk the directed script
      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            apply_debounce(script[i].setting);
         end else begin
            f.command = script[i].command;
            f.depth = script[i].depth;
            f.stamp = script[i].stamp;
            given.segment_start = script[i].want_start;
            given.segment_end = script[i].want_end;
            given.status = script[i].want_status;
            offer_frame(f, $urandom_range(0, 2), script[i].typed, given);
         end
      end

      // random walks, one debounce setting per phase
      burst_left = 0;
      for (int p = 0; p < PHASES; p++) begin
         setting = (p < 5) ? plan[p] : 4'($urandom_range(0, 15));
         apply_debounce(setting);
         // phase two fills the block against a receiver that holds off
         gappy = (p != 2) && (p != 6);
         if (p == 2) long_hold_due = 1'b1;
         for (int n = 0; n < PHASE_FRAMES; n++) begin
            gap = 0;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 30);
               if (gappy) gap = $urandom_range(1, 12);
            end
            burst_left--;
            offer_frame(next_walk_frame(), gap, 1'b0, '0);
         end
      end

      // wait for the tail of results, then for the pipeline to go quiet
      req_tvalid <= 1'b0;
      while (segment_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d frames (%0d end markers) under %0d debounce settings.",
               frames_sent, markers_sent, settings_used);
      $display("Checked %0d turn, %0d end-of-stream and %0d aborted segments.",
               turns_seen, ends_seen, aborts_seen);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result receiver: ready runs of random length, short stalls, now and
   // then a long clean stretch, and one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin
      @(posedge clock);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(100, 300)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: every transfer against the oldest expected segment
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      wds_pkg::result_type got;
      wds_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.segment_start = rsp_tdata[31:0];
         got.segment_end = rsp_tdata[63:32];
         got.status = rsp_tdata[65:64];
         case (got.status)
            TURN:    turns_seen++;
            CLOSED:  ends_seen++;
            ABORTED: aborts_seen++;
            default: ;
         endcase
         if (segment_due.size() == 0) begin
            $display("%0t: unexpected segment, expected none actual %h %h %h",
                     $time, got.segment_start, got.segment_end, got.status);
            errors++;
         end else begin
            want = segment_due.pop_front();
            if (got.segment_start !== want.segment_start) begin
               $display("%0t: segment_start expected %h actual %h",
                        $time, want.segment_start, got.segment_start);
               errors++;
            end
            if (got.segment_end !== want.segment_end) begin
               $display("%0t: segment_end expected %h actual %h",
                        $time, want.segment_end, got.segment_end);
               errors++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status expected %h actual %h",
                        $time, want.status, got.status);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: count cycles with no transfer on any port
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d segments still due",
                  $time, idle_cycles, segment_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule
